FILE: rtl/ovs_pkg.sv
// Shared constants, types and helpers of the overload victim selector.
package ovs_pkg;

    localparam int VALUE_W         = 10;
    localparam int LEVEL_W         = 14;
    localparam int IDX_OUT_W       = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int PICK_IDX_W      = 7;
    localparam int NUM_TOT         = 6;
    localparam int MAX_CLIENTS_DEF = 16;
    localparam int LANES_DEF       = 4;

    // step total slots: CPU steps then memory steps
    localparam int TOT_CPU0 = 0;
    localparam int TOT_CPU1 = 1;
    localparam int TOT_CPU2 = 2;
    localparam int TOT_MEM0 = 3;
    localparam int TOT_MEM1 = 4;
    localparam int TOT_MEM2 = 5;

    localparam logic [LEVEL_W-1:0] OVERLOAD_RST = LEVEL_W'(90);
    localparam logic [LEVEL_W-1:0] ALLOWED_RST  = LEVEL_W'(80);

    localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_MERGE
    } ovs_state_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_W-1:0]    value;
        logic [PICK_IDX_W-1:0] idx;
    } pick_t;

    // a beats b: smaller value, earlier client on a tie
    function automatic logic pick_wins(pick_t a, pick_t b);
        logic wins;
        wins = a.found && (!b.found || (a.value < b.value) ||
                           ((a.value == b.value) && (a.idx < b.idx)));
        return wins;
    endfunction

endpackage

FILE: rtl/ovs_if.sv
// Channel interfaces: client items, selection results and register writes.
interface ovs_in_if;
    logic                        valid;
    logic                        ready;
    logic [ovs_pkg::VALUE_W-1:0] cpu_step0;
    logic [ovs_pkg::VALUE_W-1:0] cpu_step1;
    logic [ovs_pkg::VALUE_W-1:0] cpu_step2;
    logic [ovs_pkg::VALUE_W-1:0] mem_step0;
    logic [ovs_pkg::VALUE_W-1:0] mem_step1;
    logic [ovs_pkg::VALUE_W-1:0] mem_step2;
    logic                        last_client;

    modport source (
        output valid, cpu_step0, cpu_step1, cpu_step2,
               mem_step0, mem_step1, mem_step2, last_client,
        input  ready
    );
    modport sink (
        input  valid, cpu_step0, cpu_step1, cpu_step2,
               mem_step0, mem_step1, mem_step2, last_client,
        output ready
    );
endinterface

interface ovs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          victim_found;
    logic [ovs_pkg::IDX_OUT_W-1:0] victim_index;
    logic                          cpu_overload;
    logic                          mem_overload;

    modport source (
        output valid, victim_found, victim_index, cpu_overload, mem_overload,
        input  ready
    );
    modport sink (
        input  valid, victim_found, victim_index, cpu_overload, mem_overload,
        output ready
    );
endinterface

interface ovs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ovs_pkg::CFG_IDX_W-1:0] index;
    logic [ovs_pkg::LEVEL_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/overload_victim_selector_core.sv
// Overload victim selector: top level with loading, lane scan control and result register.
//
// Clients stream in one transaction per cycle; each transaction adds the client's
// predicted CPU and memory usage for three future steps to six saturating step
// totals (14 bits, clipped at 16383) and stores its third-step values in the
// lane banks, client k going to lane k mod LANES. Clients beyond MAX_CLIENTS in
// a round are dropped. The transaction marked last_client closes the round:
// the input then stalls while all lanes read their banks in parallel, one row
// per cycle, each keeping the smallest third-step value whose removal leaves
// the third-step total at or below allowed_level (earliest client on ties).
// After the scan a merging stage combines the lanes, and the result
// transaction goes to the output register. The length of the scan is set by
// the single read port of each lane bank. The next round may start loading
// while the result still waits to be taken. A memory pick overrides the CPU
// pick; a resource only picks when all three of its step totals exceed
// overload_level. victim_index carries the low four bits of the client
// position. LANES must be a power of two, at least 2. Register writes are
// always accepted and must only be made while the block is idle.
module overload_victim_selector_core #(
    parameter int MAX_CLIENTS = ovs_pkg::MAX_CLIENTS_DEF,
    parameter int LANES       = ovs_pkg::LANES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ovs_cfg_if.sink    cfg,
    ovs_in_if.sink     item,
    ovs_out_if.source  result
);
    import ovs_pkg::*;

    localparam int LSEL_W  = $clog2(LANES);
    localparam int BANK_D  = (MAX_CLIENTS + LANES - 1) / LANES;
    localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int CNT_W   = $clog2(MAX_CLIENTS + 1);

    // control state
    ovs_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LSEL_W-1:0]  wr_lane_reg, wr_lane_next;
    logic [BANK_AW-1:0] wr_addr_reg, wr_addr_next;
    logic [BANK_AW-1:0] rd_row_reg, rd_row_next;
    logic [LEVEL_W-1:0] tot_reg [NUM_TOT];
    logic [LEVEL_W-1:0] tot_next [NUM_TOT];
    logic [LEVEL_W-1:0] overload_reg, allowed_reg;
    logic               out_vld_reg, out_vld_next;

    // result payload
    logic                 found_reg, found_next;
    logic [IDX_OUT_W-1:0] index_reg, index_next;
    logic                 cpu_ov_reg, cpu_ov_next;
    logic                 mem_ov_reg, mem_ov_next;

    // strobes from the state machine
    logic in_rdy, rd_en, merge_ok, lane_clear;
    logic item_acc, store_en, scan_last, room;

    logic [VALUE_W-1:0] step_val [NUM_TOT];
    pick_t              cpu_lane [LANES];
    pick_t              mem_lane [LANES];
    pick_t              cpu_pick, mem_pick;

    // ------------------------------------------------------------------
    // Register writes: always ready, unknown indexes are dropped
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overload_reg <= OVERLOAD_RST;
            allowed_reg  <= ALLOWED_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_OVERLOAD: overload_reg <= cfg.data;
                REG_ALLOWED:  allowed_reg  <= cfg.data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Round sequencer: load, scan the banks, let the last row settle, merge
    // ------------------------------------------------------------------
    assign item_acc  = item.valid && in_rdy;
    assign room      = cnt_reg < CNT_W'(MAX_CLIENTS);
    assign store_en  = item_acc && room;
    assign scan_last = rd_row_reg == BANK_AW'(BANK_D - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_acc && item.last_client)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_MERGE;
            ST_MERGE:
            begin
                if (merge_ok)
                    state_next = ST_LOAD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        in_rdy   = 1'b0;
        rd_en    = 1'b0;
        merge_ok = 1'b0;
        unique case (state_reg)
            ST_LOAD:  in_rdy   = 1'b1;
            ST_SCAN:  rd_en    = 1'b1;
            ST_DRAIN: ;
            ST_MERGE: merge_ok = !out_vld_reg || result.ready;
            default:  ;
        endcase
    end

    // lanes restart their search as the round closes
    assign lane_clear = item_acc && item.last_client;
    assign item.ready = in_rdy;

    // ------------------------------------------------------------------
    // Loading: saturating step totals and bank write pointer
    // ------------------------------------------------------------------
    assign step_val[TOT_CPU0] = item.cpu_step0;
    assign step_val[TOT_CPU1] = item.cpu_step1;
    assign step_val[TOT_CPU2] = item.cpu_step2;
    assign step_val[TOT_MEM0] = item.mem_step0;
    assign step_val[TOT_MEM1] = item.mem_step1;
    assign step_val[TOT_MEM2] = item.mem_step2;

    always_comb
    begin
        logic [LEVEL_W:0] sum;
        for (int s = 0; s < NUM_TOT; s++)
        begin
            sum = {1'b0, tot_reg[s]} + (LEVEL_W + 1)'(step_val[s]);
            if (merge_ok)
                tot_next[s] = '0;
            else if (store_en)
                tot_next[s] = sum[LEVEL_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
            else
                tot_next[s] = tot_reg[s];
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        wr_lane_next = wr_lane_reg;
        wr_addr_next = wr_addr_reg;
        if (merge_ok)
        begin
            cnt_next     = '0;
            wr_lane_next = '0;
            wr_addr_next = '0;
        end
        else if (store_en)
        begin
            cnt_next     = cnt_reg + CNT_W'(1);
            wr_lane_next = wr_lane_reg + LSEL_W'(1);
            // advance to the next row once every lane has taken a client
            if (wr_lane_reg == {LSEL_W{1'b1}})
                wr_addr_next = wr_addr_reg + BANK_AW'(1);
        end
    end

    assign rd_row_next = (rd_en && !scan_last) ? rd_row_reg + BANK_AW'(1) : '0;

    // ------------------------------------------------------------------
    // Lanes and merging stage
    // ------------------------------------------------------------------
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        ovs_lane #(
            .LANE_ID (g),
            .LSEL_W  (LSEL_W),
            .BANK_D  (BANK_D),
            .BANK_AW (BANK_AW),
            .CNT_W   (CNT_W)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (store_en && (wr_lane_reg == LSEL_W'(g))),
            .wr_addr   (wr_addr_reg),
            .wr_cpu    (item.cpu_step2),
            .wr_mem    (item.mem_step2),
            .rd_en     (rd_en),
            .rd_addr   (rd_row_reg),
            .clear     (lane_clear),
            .cpu_total (tot_reg[TOT_CPU2]),
            .mem_total (tot_reg[TOT_MEM2]),
            .allowed   (allowed_reg),
            .cnt       (cnt_reg),
            .cpu_best  (cpu_lane[g]),
            .mem_best  (mem_lane[g])
        );
    end

    ovs_merge #(
        .LANES (LANES)
    ) u_merge (
        .cpu_lane (cpu_lane),
        .mem_lane (mem_lane),
        .cpu_pick (cpu_pick),
        .mem_pick (mem_pick)
    );

    // ------------------------------------------------------------------
    // Result register: overload tests, memory pick overrides CPU pick
    // ------------------------------------------------------------------
    always_comb
    begin
        cpu_ov_next = (tot_reg[TOT_CPU0] > overload_reg)
                   && (tot_reg[TOT_CPU1] > overload_reg)
                   && (tot_reg[TOT_CPU2] > overload_reg);
        mem_ov_next = (tot_reg[TOT_MEM0] > overload_reg)
                   && (tot_reg[TOT_MEM1] > overload_reg)
                   && (tot_reg[TOT_MEM2] > overload_reg);
        found_next  = 1'b0;
        index_next  = '0;
        if (mem_ov_next && mem_pick.found)
        begin
            found_next = 1'b1;
            index_next = IDX_OUT_W'(mem_pick.idx);
        end
        else if (cpu_ov_next && cpu_pick.found)
        begin
            found_next = 1'b1;
            index_next = IDX_OUT_W'(cpu_pick.idx);
        end
    end

    assign out_vld_next = merge_ok ? 1'b1 : (result.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk)
    begin
        if (merge_ok)
        begin
            found_reg  <= found_next;
            index_reg  <= index_next;
            cpu_ov_reg <= cpu_ov_next;
            mem_ov_reg <= mem_ov_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            wr_lane_reg <= '0;
            wr_addr_reg <= '0;
            rd_row_reg  <= '0;
            out_vld_reg <= 1'b0;
            for (int s = 0; s < NUM_TOT; s++)
                tot_reg[s] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wr_lane_reg <= wr_lane_next;
            wr_addr_reg <= wr_addr_next;
            rd_row_reg  <= rd_row_next;
            out_vld_reg <= out_vld_next;
            for (int s = 0; s < NUM_TOT; s++)
                tot_reg[s] <= tot_next[s];
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.victim_found = found_reg;
    assign result.victim_index = index_reg;
    assign result.cpu_overload = cpu_ov_reg;
    assign result.mem_overload = mem_ov_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a new result only ever comes out of the merge step
    a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_MERGE))
        else $error("result raised outside merge");

    // client count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CLIENTS))
        else $error("client count beyond capacity");

    // a victim needs an overloaded resource
    a_victim_needs_overload: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.victim_found) |->
            (result.cpu_overload || result.mem_overload))
        else $error("victim without overload");

    // inputs are held off for the whole scan
    a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !item.ready)
        else $error("input taken during scan");
`endif

endmodule

FILE: rtl/ovs_lane.sv
// One scan lane: a bank of stored third-step values and its running best picks.
module ovs_lane #(
    parameter int LANE_ID = 0,
    parameter int LSEL_W  = 2,
    parameter int BANK_D  = 4,
    parameter int BANK_AW = 2,
    parameter int CNT_W   = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [BANK_AW-1:0]           wr_addr,
    input  logic [ovs_pkg::VALUE_W-1:0]  wr_cpu,
    input  logic [ovs_pkg::VALUE_W-1:0]  wr_mem,
    input  logic                         rd_en,
    input  logic [BANK_AW-1:0]           rd_addr,
    input  logic                         clear,
    input  logic [ovs_pkg::LEVEL_W-1:0]  cpu_total,
    input  logic [ovs_pkg::LEVEL_W-1:0]  mem_total,
    input  logic [ovs_pkg::LEVEL_W-1:0]  allowed,
    input  logic [CNT_W-1:0]             cnt,
    output ovs_pkg::pick_t               cpu_best,
    output ovs_pkg::pick_t               mem_best
);
    import ovs_pkg::*;

    localparam int XW = BANK_AW + LSEL_W;

    logic [VALUE_W-1:0] cpu_bank_reg [BANK_D];
    logic [VALUE_W-1:0] mem_bank_reg [BANK_D];
    logic [VALUE_W-1:0] cpu_rd_reg, mem_rd_reg;
    logic [BANK_AW-1:0] rd_row_reg;
    logic               rd_vld_reg;

    logic               cpu_found_reg, mem_found_reg;
    logic [VALUE_W-1:0] cpu_best_reg, mem_best_reg;
    logic [XW-1:0]      cpu_idx_reg, mem_idx_reg;

    logic [XW-1:0]      cand_idx;
    logic               cand_vld;
    logic               cpu_take, mem_take;

    // bank storage, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cpu_bank_reg[wr_addr] <= wr_cpu;
            mem_bank_reg[wr_addr] <= wr_mem;
        end
        if (rd_en)
        begin
            cpu_rd_reg <= cpu_bank_reg[rd_addr];
            mem_rd_reg <= mem_bank_reg[rd_addr];
            rd_row_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= rd_en;
    end

    // client number of this row in this lane; drop entries beyond the round
    assign cand_idx = {rd_row_reg, LSEL_W'(LANE_ID)};
    assign cand_vld = rd_vld_reg && ({1'b0, cand_idx} < (XW + 1)'(cnt));

    assign cpu_take = cand_vld
        && ({1'b0, cpu_total} <= ({1'b0, allowed} + (LEVEL_W + 1)'(cpu_rd_reg)))
        && (!cpu_found_reg || (cpu_rd_reg < cpu_best_reg));
    assign mem_take = cand_vld
        && ({1'b0, mem_total} <= ({1'b0, allowed} + (LEVEL_W + 1)'(mem_rd_reg)))
        && (!mem_found_reg || (mem_rd_reg < mem_best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_found_reg <= 1'b0;
            mem_found_reg <= 1'b0;
        end
        else if (clear)
        begin
            cpu_found_reg <= 1'b0;
            mem_found_reg <= 1'b0;
        end
        else
        begin
            if (cpu_take)
                cpu_found_reg <= 1'b1;
            if (mem_take)
                mem_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cpu_take)
        begin
            cpu_best_reg <= cpu_rd_reg;
            cpu_idx_reg  <= cand_idx;
        end
        if (mem_take)
        begin
            mem_best_reg <= mem_rd_reg;
            mem_idx_reg  <= cand_idx;
        end
    end

    assign cpu_best.found = cpu_found_reg;
    assign cpu_best.value = cpu_best_reg;
    assign cpu_best.idx   = PICK_IDX_W'(cpu_idx_reg);
    assign mem_best.found = mem_found_reg;
    assign mem_best.value = mem_best_reg;
    assign mem_best.idx   = PICK_IDX_W'(mem_idx_reg);

endmodule

FILE: rtl/ovs_merge.sv
// Combine the per-lane best picks into one pick per resource.
module ovs_merge #(
    parameter int LANES = 4
) (
    input  ovs_pkg::pick_t cpu_lane [LANES],
    input  ovs_pkg::pick_t mem_lane [LANES],
    output ovs_pkg::pick_t cpu_pick,
    output ovs_pkg::pick_t mem_pick
);
    import ovs_pkg::*;

    always_comb
    begin
        pick_t cpu_acc;
        pick_t mem_acc;
        cpu_acc = cpu_lane[0];
        mem_acc = mem_lane[0];
        for (int i = 1; i < LANES; i++)
        begin
            if (pick_wins(cpu_lane[i], cpu_acc))
                cpu_acc = cpu_lane[i];
            if (pick_wins(mem_lane[i], mem_acc))
                mem_acc = mem_lane[i];
        end
        cpu_pick = cpu_acc;
        mem_pick = mem_acc;
    end

endmodule
